### design/dex_pkg.sv
// Shared types, constants and helpers for the dictionary entry text field extractor.
// No dependencies; every other design file refers to this package by scoped names.

package dex_pkg;

	// Largest number of configured field types in sequence mode
	localparam int unsigned MAX_TYPES = 8;

	// Depth of the queue between the front and back parts
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic CFG_TYPE_SEQ_LENGTH = 1'b0;
	localparam logic CFG_SEQ_TEXT_MASK   = 1'b1;

	// Byte values that matter to the parser
	localparam logic [7:0] CH_M   = 8'h6D;
	localparam logic [7:0] CH_L   = 8'h6C;
	localparam logic [7:0] CH_G   = 8'h67;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_H   = 8'h68;
	localparam logic [7:0] CH_K   = 8'h6B;
	localparam logic [7:0] CH_W   = 8'h77;
	localparam logic [7:0] CH_Y   = 8'h79;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	// Parse phases of the back part
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_FIELD = 3'd1,
		PH_TEXT  = 3'd2,
		PH_SIZE  = 3'd3,
		PH_SKIP  = 3'd4,
		PH_RAW   = 3'd5,
		PH_DRAIN = 3'd6
	} phase_t;

	// A classified input byte as it travels through the queue
	typedef struct packed {
		logic        start;     // first byte of a new entry
		logic [31:0] len_m1;    // bytes that follow the first one (valid with start)
		logic [7:0]  data;      // raw entry byte
		logic        text_type; // byte is one of the text field type codes
		logic        is_nul;    // byte is a NUL
	} item_t;

	// Live configuration seen by the parser
	typedef struct packed {
		logic [3:0] seq_len;    // clamped to MAX_TYPES
		logic [7:0] text_mask;
	} cfg_t;

	// One result request
	typedef struct packed {
		logic        newline_before;
		logic [31:0] zero_run;
		logic        char_valid;
		logic [7:0]  char_byte;
		logic        entry_done;
	} result_t;

	// Queue handshake signals seen by the consumer
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

	// True for the type bytes that open a text field
	function automatic logic text_field_code(input logic [7:0] b);
		logic r;
		begin
			case (b)
				CH_M, CH_L, CH_G, CH_T, CH_X, CH_H, CH_K, CH_W, CH_Y: r = 1'b1;
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

endpackage

### design/dex_front.sv
// Front part: registers each accepted input request and classifies its byte.
// Depends on dex_pkg for the item type and the type byte decoder.

module dex_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [39:0]        s_axis_tdata,  // entry_length[31:0], data_byte[39:32]
	input  logic               s_axis_tuser,  // entry_start
	output logic               push,
	output dex_pkg::item_t     push_item,
	input  logic               q_full
);

	logic           valid_s1;
	dex_pkg::item_t item_s1;
	logic [31:0]    len;
	logic [7:0]     data;
	logic           take;

	assign len  = s_axis_tdata[31:0];
	assign data = s_axis_tdata[39:32];

	// The stage moves on when empty or when the queue takes its item
	assign push          = valid_s1 && !q_full;
	assign s_axis_tready = !valid_s1 || !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign push_item     = item_s1;

	// Valid flag of the classification stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Classified payload; a zero length counts as one byte
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.start     <= s_axis_tuser;
			item_s1.len_m1    <= (len == 32'd0) ? 32'd0 : len - 32'd1;
			item_s1.data      <= data;
			item_s1.text_type <= dex_pkg::text_field_code(data);
			item_s1.is_nul    <= (data == dex_pkg::CH_NUL);
		end
	end

endmodule

### design/dex_queue.sv
// Short register queue between the front and back parts of the extractor.
// Depends on dex_pkg for the depth constants and the item type.

module dex_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dex_pkg::item_t      push_item,
	output logic                full,
	input  logic                pop,
	output dex_pkg::q_out_t     head
);

	dex_pkg::item_t                  entry_q [dex_pkg::QDEPTH];
	logic [dex_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [dex_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [dex_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full       = (count_q == dex_pkg::QCNT_W'(dex_pkg::QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### design/dex_back.sv
// Back part: the entry parser state machine and the output register.
// Depends on dex_pkg for the phase enum, item, configuration and result types.

module dex_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dex_pkg::cfg_t      cfg,
	input  dex_pkg::q_out_t    head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output dex_pkg::result_t   result
);

	dex_pkg::phase_t   phase_q;
	logic [3:0]        pos_q;
	logic [31:0]       left_q;   // bytes that follow the next byte of the entry
	logic [31:0]       acc_q;
	logic [1:0]        seen_q;
	logic [31:0]       skip_q;
	logic              nonempty_q;
	logic [31:0]       zeros_q;
	logic              out_valid_q;
	dex_pkg::result_t  out_q;

	dex_pkg::phase_t   phase_n;
	logic [3:0]        pos_n;
	logic [31:0]       left_n;
	logic [31:0]       acc_n;
	logic [1:0]        seen_n;
	logic [31:0]       skip_n;
	logic              nonempty_n;
	logic [31:0]       zeros_n;
	logic              has_result;
	dex_pkg::result_t  res;

	// A queued byte is handled whenever the output slot is free or draining
	assign pop           = head.valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign result        = out_q;

	// Parser step for the byte at the head of the queue
	always_comb begin
		dex_pkg::phase_t ph_c;
		logic [3:0]      pos_c;
		logic [31:0]     acc_c;
		logic [1:0]      seen_c;
		logic [31:0]     skip_c;
		logic            ne_c;
		logic [31:0]     zeros_c;
		logic [31:0]     after;
		logic [31:0]     acc_new;
		logic            body;
		logic            lastf;
		logic            active;

		ph_c    = phase_q;
		pos_c   = pos_q;
		acc_c   = acc_q;
		seen_c  = seen_q;
		skip_c  = skip_q;
		ne_c    = nonempty_q;
		zeros_c = zeros_q;
		after   = left_q;
		active  = 1'b1;
		if (head.item.start) begin
			ph_c    = dex_pkg::PH_FIELD;
			pos_c   = '0;
			acc_c   = '0;
			seen_c  = '0;
			skip_c  = '0;
			ne_c    = 1'b0;
			zeros_c = '0;
			after   = head.item.len_m1;
		end else if (phase_q == dex_pkg::PH_IDLE) begin
			active = 1'b0;
		end

		phase_n    = ph_c;
		pos_n      = pos_c;
		acc_n      = acc_c;
		seen_n     = seen_c;
		skip_n     = skip_c;
		nonempty_n = ne_c;
		zeros_n    = zeros_c;
		left_n     = after - 32'd1;
		body       = 1'b1;
		acc_new    = {acc_c[23:0], head.item.data};
		lastf      = ((pos_c + 4'd1) == cfg.seq_len);
		res        = '0;

		// Field boundaries, size header and skipped payload
		case (ph_c)
			dex_pkg::PH_FIELD: begin
				if (cfg.seq_len != 4'd0) begin
					if (pos_c >= cfg.seq_len) begin
						phase_n = dex_pkg::PH_DRAIN;
					end else begin
						pos_n = pos_c + 4'd1;
						if (cfg.text_mask[pos_c[2:0]]) begin
							res.newline_before = ne_c;
							phase_n = lastf ? dex_pkg::PH_RAW : dex_pkg::PH_TEXT;
						end else if (lastf || after < 32'd3) begin
							phase_n = dex_pkg::PH_DRAIN;
						end else begin
							acc_n   = {24'd0, head.item.data};
							seen_n  = 2'd1;
							phase_n = dex_pkg::PH_SIZE;
							body    = 1'b0;
						end
					end
				end else begin
					body = 1'b0;
					if (head.item.text_type) begin
						res.newline_before = ne_c;
						phase_n = dex_pkg::PH_TEXT;
					end else if (after < 32'd4) begin
						phase_n = dex_pkg::PH_DRAIN;
					end else begin
						acc_n   = '0;
						seen_n  = '0;
						phase_n = dex_pkg::PH_SIZE;
					end
				end
			end
			dex_pkg::PH_SIZE: begin
				body  = 1'b0;
				acc_n = acc_new;
				if (seen_c == 2'd3) begin
					seen_n = '0;
					if (acc_new > after) begin
						phase_n = dex_pkg::PH_DRAIN;
					end else if (acc_new == 32'd0) begin
						phase_n = dex_pkg::PH_FIELD;
					end else begin
						skip_n  = acc_new;
						phase_n = dex_pkg::PH_SKIP;
					end
				end else begin
					seen_n = seen_c + 2'd1;
				end
			end
			dex_pkg::PH_SKIP: begin
				body   = 1'b0;
				skip_n = skip_c - 32'd1;
				if (skip_c == 32'd1) begin
					phase_n = dex_pkg::PH_FIELD;
				end
			end
			default: begin
			end
		endcase

		// Text and raw field bytes
		if (body) begin
			if (phase_n == dex_pkg::PH_TEXT) begin
				if (head.item.is_nul) begin
					phase_n = dex_pkg::PH_FIELD;
				end else begin
					res.char_valid = 1'b1;
					res.char_byte  = head.item.data;
					nonempty_n     = 1'b1;
				end
			end else if (phase_n == dex_pkg::PH_RAW) begin
				if (head.item.is_nul) begin
					if (zeros_c != 32'hFFFF_FFFF) begin
						zeros_n = zeros_c + 32'd1;
					end
				end else begin
					res.zero_run   = zeros_c;
					res.char_valid = 1'b1;
					res.char_byte  = head.item.data;
					zeros_n        = '0;
				end
				nonempty_n = 1'b1;
			end
		end

		// End of entry
		if (after == 32'd0) begin
			res.entry_done = 1'b1;
			phase_n        = dex_pkg::PH_IDLE;
			zeros_n        = '0;
		end

		has_result = active &&
			(res.newline_before || res.char_valid || res.entry_done);
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dex_pkg::PH_IDLE;
			pos_q      <= '0;
			left_q     <= '0;
			acc_q      <= '0;
			seen_q     <= '0;
			skip_q     <= '0;
			nonempty_q <= 1'b0;
			zeros_q    <= '0;
		end else if (pop && (head.item.start || phase_q != dex_pkg::PH_IDLE)) begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			left_q     <= left_n;
			acc_q      <= acc_n;
			seen_q     <= seen_n;
			skip_q     <= skip_n;
			nonempty_q <= nonempty_n;
			zeros_q    <= zeros_n;
		end
	end

	// Output request flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= has_result;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop && has_result) begin
			out_q <= res;
		end
	end

	// A held NUL run is only ever released in front of a text byte
	a_zero_run_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.zero_run != 32'd0) |-> out_q.char_valid)
		else $error("zero run without a character");

	// A character byte is never a NUL
	a_char_not_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.char_valid |-> (out_q.char_byte != dex_pkg::CH_NUL))
		else $error("NUL passed as a character");

	// The end of an entry returns the parser to idle
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		pop && has_result && res.entry_done |=> (phase_q == dex_pkg::PH_IDLE))
		else $error("parser not idle after end of entry");

	// A payload skip always has bytes left to skip
	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dex_pkg::PH_SKIP) |-> (skip_q != 32'd0))
		else $error("skip phase with an empty count");

endmodule

### design/dict_entry_text_field_extractor_top.sv
// Top level of the dictionary entry text field extractor.
// Depends on dex_pkg, dex_front, dex_queue and dex_back.
//
// Usage:
//   The input stream carries one entry byte per request: tdata holds the entry
//   length (bits 31:0, read only on the first byte) and the byte (bits 39:32);
//   tuser marks the first byte of an entry. The output stream carries one
//   request for every byte that gives a newline, a text character or the end
//   of an entry: tdata holds newline_before, zero_run, char_valid and
//   char_byte, and tlast marks the entry's last byte.
//   The configuration port writes type_seq_length (index 0) and
//   seq_text_mask (index 1); write it only while no entry is in flight.
// Rate and data path:
//   One byte per cycle, sustained while the receiver accepts results. Each
//   byte is registered in the classification stage, written into the queue
//   and then parsed into the output register.
// Reset and stalls:
//   Reset empties the pipeline and the queue, returns the parser to idle and
//   clears both configuration registers. When the receiver stalls, the output
//   register holds its request, the four-entry queue and then the
//   classification stage fill, and only then does the input side drop tready.

module dict_entry_text_field_extractor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // entry_length[31:0], data_byte[39:32]
	input  logic        s_axis_tuser,  // entry_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // newline_before[0], zero_run[32:1],
	                                   // char_valid[33], char_byte[41:34], zero[47:42]
	output logic        m_axis_tlast   // entry_done
);

	logic [3:0]         seq_len_q;
	logic [7:0]         text_mask_q;
	dex_pkg::cfg_t      cfg;
	logic               push;
	dex_pkg::item_t     push_item;
	logic               q_full;
	logic               pop;
	dex_pkg::q_out_t    head;
	dex_pkg::result_t   result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q   <= '0;
			text_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dex_pkg::CFG_TYPE_SEQ_LENGTH: seq_len_q   <= cfg_data[3:0];
				dex_pkg::CFG_SEQ_TEXT_MASK:   text_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequence lengths beyond the supported count act as the maximum
	assign cfg.seq_len   = (seq_len_q > 4'(dex_pkg::MAX_TYPES)) ?
		4'(dex_pkg::MAX_TYPES) : seq_len_q;
	assign cfg.text_mask = text_mask_q;

	dex_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_item     (push_item),
		.q_full        (q_full)
	);

	dex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	dex_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.result        (result)
	);

	// Output packing
	assign m_axis_tdata = {6'd0, result.char_byte, result.char_valid,
		result.zero_run, result.newline_before};
	assign m_axis_tlast = result.entry_done;

endmodule
